/* rtl/npcs_pkg.sv */
package npcs_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int COLOR_W = 8;
    localparam int ENTRY_W = 3 * COLOR_W;
    localparam int INDEX_W = 8;
    // Largest distance is 3 * 255 * 255, which fits in 18 bits.
    localparam int DIST_W  = 2 * COLOR_W + 2;
    localparam int BOUND_W = 21;

    localparam logic [BOUND_W-1:0] START_BOUND = BOUND_W'(1 << 20);
    localparam logic [INDEX_W-1:0] START_BEST  = INDEX_W'(255);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Tag that travels with each palette read down the scan pipeline.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [INDEX_W-1:0] idx;
    } scan_tag_t;

endpackage

/* rtl/npcs_if.sv */
interface npcs_req_if import npcs_pkg::*;;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (
        output valid, operation, entry_index, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, red, green, blue,
        output ready
    );
endinterface

interface npcs_rsp_if import npcs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] best_index;

    modport source (
        output valid, best_index,
        input  ready
    );
    modport sink (
        input  valid, best_index,
        output ready
    );
endinterface

/* rtl/npcs_palette_mem.sv */
module npcs_palette_mem import npcs_pkg::*; #(
    parameter int DEPTH  = PALETTE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/npcs_dist_calc.sv */
module npcs_dist_calc import npcs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ENTRY_W-1:0] entry,
    input  logic [COLOR_W-1:0] q_red,
    input  logic [COLOR_W-1:0] q_green,
    input  logic [COLOR_W-1:0] q_blue,
    input  scan_tag_t          tag_in,
    output logic [DIST_W-1:0]  distance,
    output scan_tag_t          tag_out
);

    logic [COLOR_W-1:0]   d_red;
    logic [COLOR_W-1:0]   d_green;
    logic [COLOR_W-1:0]   d_blue;
    logic [2*COLOR_W-1:0] sq_red;
    logic [2*COLOR_W-1:0] sq_green;
    logic [2*COLOR_W-1:0] sq_blue;
    logic [DIST_W-1:0]    dist_next;
    logic [COLOR_W-1:0]   e_red;
    logic [COLOR_W-1:0]   e_green;
    logic [COLOR_W-1:0]   e_blue;

    assign e_red   = entry[COLOR_W-1:0];
    assign e_green = entry[2*COLOR_W-1:COLOR_W];
    assign e_blue  = entry[3*COLOR_W-1:2*COLOR_W];

    always_comb
    begin
        d_red     = (e_red > q_red) ? (e_red - q_red) : (q_red - e_red);
        d_green   = (e_green > q_green) ? (e_green - q_green) : (q_green - e_green);
        d_blue    = (e_blue > q_blue) ? (e_blue - q_blue) : (q_blue - e_blue);
        sq_red    = d_red * d_red;
        sq_green  = d_green * d_green;
        sq_blue   = d_blue * d_blue;
        dist_next = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
    end

    always_ff @(posedge clk)
    begin
        distance <= dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out <= '0;
        end
        else
        begin
            tag_out <= tag_in;
        end
    end

endmodule

/* rtl/nearest_palette_color_search_unit.sv */
// Nearest palette color search. The block holds a palette of PALETTE_ENTRIES
// RGB entries in one synchronous memory, loaded by write requests (operation
// 0, entry_index, red, green, blue); writes at or above PALETTE_ENTRIES are
// dropped. A query request (operation 1) carries an RGB color and returns one
// response with the index of the entry at the least squared Euclidean
// distance, the lowest index on a tie; only the low 8 bits of the index are
// returned. Every entry must be written before the first query reads it.
// A query goes from acceptance to the response being offered in steps: the
// single memory read port delivers one entry per cycle, the last entry then
// passes a registered distance stage and a compare stage, and after that the
// response register is loaded. Requests are accepted only between queries; a
// write may be taken while a response still waits, and the next query runs
// while it waits, holding its own result until the response register is free.
module nearest_palette_color_search_unit import npcs_pkg::*; #(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    npcs_req_if.sink req,
    npcs_rsp_if.source rsp
);

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

    state_t state_reg;
    state_t state_next;

    logic [ADDR_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0]  cnt_next;
    logic [COLOR_W-1:0] q_red_reg;
    logic [COLOR_W-1:0] q_green_reg;
    logic [COLOR_W-1:0] q_blue_reg;
    scan_tag_t          s1_tag_reg;
    scan_tag_t          s1_tag_next;
    logic [BOUND_W-1:0] bound_reg;
    logic [BOUND_W-1:0] bound_next;
    logic [INDEX_W-1:0] best_reg;
    logic [INDEX_W-1:0] best_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;

    logic               req_accept;
    logic               query_accept;
    logic               mem_we;
    logic               mem_re;
    logic               load_out;
    logic               in_ready;
    logic               wr_in_range;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [DIST_W-1:0]  distance;
    scan_tag_t          dist_tag;

    assign req.ready    = in_ready;
    assign req_accept   = req.valid && in_ready;
    assign query_accept = req_accept && (req.operation == OP_QUERY);
    assign wr_in_range  = 32'(req.entry_index) < PALETTE_ENTRIES;

    assign rsp.valid      = out_valid_reg;
    assign rsp.best_index = out_index_reg;

    // Next state: scan issues one read a cycle, drain waits for the last
    // distance to be compared, finish waits for a free response register.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (dist_tag.valid && dist_tag.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller. Palette writes happen only in idle, so a
    // scan never reads an entry that is being written.
    always_comb
    begin
        in_ready = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                mem_we   = req.valid && (req.operation == OP_WRITE) && wr_in_range;
            end
            ST_SCAN:
            begin
                mem_re = 1'b1;
            end
            ST_DRAIN:
            begin
                mem_re = 1'b0;
            end
            ST_FINISH:
            begin
                load_out = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Scan address and the tag of the read in flight.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (query_accept)
        begin
            cnt_next = '0;
        end
        else if (mem_re && (cnt_reg != LAST_ADDR))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        s1_tag_next.valid = mem_re;
        s1_tag_next.last  = mem_re && (cnt_reg == LAST_ADDR);
        s1_tag_next.idx   = INDEX_W'(cnt_reg);
    end

    // Compare stage: replace the best only on a strictly smaller distance.
    always_comb
    begin
        bound_next = bound_reg;
        best_next  = best_reg;
        if (query_accept)
        begin
            bound_next = START_BOUND;
            best_next  = START_BEST;
        end
        else if (dist_tag.valid && (BOUND_W'(distance) < bound_reg))
        begin
            bound_next = BOUND_W'(distance);
            best_next  = dist_tag.idx;
        end
    end

    // Response register: load on finish, drop when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            s1_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            s1_tag_reg    <= s1_tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg      <= bound_next;
        best_reg       <= best_next;
        if (query_accept)
        begin
            q_red_reg   <= req.red;
            q_green_reg <= req.green;
            q_blue_reg  <= req.blue;
        end
        if (load_out)
        begin
            out_index_reg <= best_reg;
        end
    end

    npcs_palette_mem #(
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_palette_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(req.entry_index)),
        .wdata ({req.blue, req.green, req.red}),
        .re    (mem_re),
        .raddr (cnt_reg),
        .rdata (mem_rdata)
    );

    npcs_dist_calc u_dist_calc (
        .clk      (clk),
        .rst_n    (rst_n),
        .entry    (mem_rdata),
        .q_red    (q_red_reg),
        .q_green  (q_green_reg),
        .q_blue   (q_blue_reg),
        .tag_in   (s1_tag_reg),
        .distance (distance),
        .tag_out  (dist_tag)
    );

    a_dist_only_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
        dist_tag.valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("distance stage active outside a scan");

    a_no_write_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE && !s1_tag_reg.valid && !dist_tag.valid))
        else $error("palette written while a scan is in flight");

    a_last_tag_index : assert property (@(posedge clk) disable iff (!rst_n)
        (dist_tag.valid && dist_tag.last) |-> (dist_tag.idx == INDEX_W'(PALETTE_ENTRIES - 1)))
        else $error("scan ended on the wrong entry");

    a_finish_loads_rsp : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && state_next == ST_IDLE) |=> (rsp.valid && state_reg == ST_IDLE))
        else $error("finished query did not reach the response register");

endmodule

/* tb/nearest_palette_color_search_unit_tb.sv */
module nearest_palette_color_search_unit_tb;
    import npcs_pkg::*;

    localparam int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF;
    // A query scans every entry, then the result passes the distance, compare and response registers.
    localparam int SCAN_LATENCY    = PALETTE_ENTRIES + 4;
    localparam int DIRECTED_ROWS   = 21;
    localparam int MIXED_ITEMS     = 200;
    localparam int MISMATCH_SHOWN  = 10;
    localparam int FEW_COLORS      = 4;

    // How a phase fills the palette: a handful of repeated colors (many ties),
    // the full color cube, or components pinned near the ends of their range.
    typedef enum int {
        PAL_FEW,
        PAL_FULL,
        PAL_EXTREME
    } palette_style_t;

    // One line of the directed table. When typed is set, best carries the
    // answer written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] entry;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               typed;
        logic [INDEX_W-1:0] best;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    npcs_req_if req_ch ();
    npcs_rsp_if rsp_ch ();

    // Our own copy of the palette: red in the low byte, blue in the high one.
    logic [ENTRY_W-1:0] palette_mirror [PALETTE_ENTRIES];
    logic [ENTRY_W-1:0] few_colors [FEW_COLORS];
    // Best index expected for each accepted query, oldest first.
    logic [INDEX_W-1:0] expected_best [$];
    logic [INDEX_W-1:0] oldest_best;
    directed_row_t      directed_rows [DIRECTED_ROWS];

    int src_idle_pct;
    int sink_idle_pct;
    int fail_count;

    nearest_palette_color_search_unit #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    always #5 clk = ~clk;

    function automatic int sq_diff(int a, int b);
        return (a - b) * (a - b);
    endfunction

    // Scan the mirror from entry 0 upward; only a strictly smaller distance
    // takes over, so the lowest index wins a tie. The start bound lies above
    // any real distance, so entry 0 always replaces the start best.
    function automatic logic [INDEX_W-1:0] nearest_color(
        logic [COLOR_W-1:0] r,
        logic [COLOR_W-1:0] g,
        logic [COLOR_W-1:0] b
    );
        int                 bound;
        int                 distance;
        logic [INDEX_W-1:0] best;
        bound = int'(START_BOUND);
        best  = START_BEST;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            distance = sq_diff(int'(palette_mirror[i][COLOR_W-1:0]), int'(r))
                     + sq_diff(int'(palette_mirror[i][2*COLOR_W-1:COLOR_W]), int'(g))
                     + sq_diff(int'(palette_mirror[i][ENTRY_W-1:2*COLOR_W]), int'(b));
            if (distance < bound)
            begin
                bound = distance;
                best  = INDEX_W'(i);
            end
        end
        return best;
    endfunction

    function automatic logic [COLOR_W-1:0] extreme_component();
        case ($urandom_range(2))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // Nudge a component by a few steps, clamped to its range.
    function automatic logic [COLOR_W-1:0] near_component(logic [COLOR_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return COLOR_W'(v);
    endfunction

    function automatic logic [ENTRY_W-1:0] styled_color(palette_style_t style);
        case (style)
            PAL_FEW:     return few_colors[$urandom_range(FEW_COLORS - 1)];
            PAL_EXTREME: return {extreme_component(), extreme_component(),
                                 extreme_component()};
            default:     return ENTRY_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        if (fail_count < MISMATCH_SHOWN)
            $display("mismatch: %s, expected %0d, got %0d", what, want, got);
        fail_count++;
    endtask

    // Offer one request and hold it until the block takes it. Ready is
    // sampled at the edge, so a high ready after the wait means the request
    // went in at that edge. Update the mirror on a write, queue the answer on
    // a query; a typed answer from the directed table takes precedence.
    task automatic send_request(
        logic               op,
        logic [INDEX_W-1:0] entry,
        logic [COLOR_W-1:0] r,
        logic [COLOR_W-1:0] g,
        logic [COLOR_W-1:0] b,
        logic               typed      = 1'b0,
        logic [INDEX_W-1:0] typed_best = '0
    );
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.entry_index <= entry;
        req_ch.red         <= r;
        req_ch.green       <= g;
        req_ch.blue        <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (op == OP_WRITE)
            palette_mirror[entry] = {b, g, r};
        else
            expected_best.push_back(typed ? typed_best : nearest_color(r, g, b));
    endtask

    // Drop valid and hold off until every queued answer has been checked.
    task automatic wait_for_responses();
        if (expected_best.size() != 0)
        begin
            req_ch.valid <= 1'b0;
            while (expected_best.size() != 0)
                @(posedge clk);
        end
    endtask

    // One random phase: reload the whole palette in the given style, then
    // a mix of writes and queries. Queries aim at random colors, at the
    // corners of the cube, and close to colors already in the palette, so
    // that exact hits and ties come up often.
    task automatic run_phase(palette_style_t style);
        int                 roll;
        logic [ENTRY_W-1:0] c;
        for (int k = 0; k < FEW_COLORS; k++)
            few_colors[k] = ENTRY_W'($urandom);
        wait_for_responses();
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            c = styled_color(style);
            send_request(OP_WRITE, INDEX_W'(i), c[COLOR_W-1:0],
                         c[2*COLOR_W-1:COLOR_W], c[ENTRY_W-1:2*COLOR_W]);
        end
        for (int n = 0; n < MIXED_ITEMS; n++)
        begin
            if ($urandom_range(99) < 3)
                wait_for_responses();
            roll = $urandom_range(99);
            if (roll < 25)
            begin
                c = styled_color(style);
                send_request(OP_WRITE, INDEX_W'($urandom), c[COLOR_W-1:0],
                             c[2*COLOR_W-1:COLOR_W], c[ENTRY_W-1:2*COLOR_W]);
            end
            else if (roll < 55)
            begin
                send_request(OP_QUERY, INDEX_W'($urandom), COLOR_W'($urandom),
                             COLOR_W'($urandom), COLOR_W'($urandom));
            end
            else if (roll < 70)
            begin
                send_request(OP_QUERY, INDEX_W'($urandom),
                             COLOR_W'($urandom_range(1) ? 255 : 0),
                             COLOR_W'($urandom_range(1) ? 255 : 0),
                             COLOR_W'($urandom_range(1) ? 255 : 0));
            end
            else
            begin
                c = palette_mirror[$urandom_range(PALETTE_ENTRIES - 1)];
                send_request(OP_QUERY, INDEX_W'($urandom),
                             near_component(c[COLOR_W-1:0]),
                             near_component(c[2*COLOR_W-1:COLOR_W]),
                             near_component(c[ENTRY_W-1:2*COLOR_W]));
            end
        end
    endtask

    // Check each response against the oldest expectation, then pick the
    // receiver's ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_best.size() == 0)
            begin
                report_mismatch("unexpected response best_index", -1,
                                int'(rsp_ch.best_index));
            end
            else
            begin
                oldest_best = expected_best.pop_front();
                if (rsp_ch.best_index !== oldest_best)
                    report_mismatch("best_index", int'(oldest_best),
                                    int'(rsp_ch.best_index));
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    initial
    begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_WRITE;
        req_ch.entry_index <= '0;
        req_ch.red         <= '0;
        req_ch.green       <= '0;
        req_ch.blue        <= '0;
        fail_count    = 0;
        src_idle_pct  = 37;
        sink_idle_pct = 70;

        // The directed rows assume the gray ramp below: entry i holds
        // (i, i, i) until a row overwrites it.
        directed_rows = '{
            // black and white hit the two ends of the ramp exactly
            '{OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
            '{OP_QUERY, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
            '{OP_QUERY, 8'd17,  8'd128, 8'd128, 8'd128, 1'b1, 8'd128},
            // one step off black: entry 0 is at distance 1, entry 1 at 2
            '{OP_QUERY, 8'd0,   8'd1,   8'd0,   8'd0,   1'b1, 8'd0},
            // saturated corners, far from every gray
            '{OP_QUERY, 8'd200, 8'd255, 8'd0,   8'd0,   1'b0, 8'd0},
            '{OP_QUERY, 8'd1,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
            '{OP_QUERY, 8'd254, 8'd0,   8'd0,   8'd255, 1'b0, 8'd0},
            '{OP_QUERY, 8'd128, 8'd255, 8'd0,   8'd255, 1'b0, 8'd0},
            // tie: entries 7 and 200 become equal, the lower one wins
            '{OP_WRITE, 8'd200, 8'd7,   8'd7,   8'd7,   1'b0, 8'd0},
            '{OP_QUERY, 8'd200, 8'd7,   8'd7,   8'd7,   1'b1, 8'd7},
            // tie at white between entries 0 and 255
            '{OP_WRITE, 8'd0,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
            '{OP_QUERY, 8'd99,  8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
            // black now lands on entry 1, the darkest gray left
            '{OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd1},
            // a real hit on entry 255, the same code as the start best
            '{OP_WRITE, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
            '{OP_QUERY, 8'd3,   8'd0,   8'd0,   8'd0,   1'b1, 8'd255},
            // one pure red entry in the middle of the ramp
            '{OP_WRITE, 8'd128, 8'd255, 8'd0,   8'd0,   1'b0, 8'd0},
            '{OP_QUERY, 8'd64,  8'd255, 8'd0,   8'd0,   1'b1, 8'd128},
            // black tie between entries 1 and 255
            '{OP_WRITE, 8'd1,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
            '{OP_QUERY, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1, 8'd1},
            '{OP_QUERY, 8'h55,  8'd201, 8'd201, 8'd201, 1'b1, 8'd201},
            '{OP_QUERY, 8'hAA,  8'd0,   8'd255, 8'd255, 1'b0, 8'd0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Load every entry before the first query: no scan may touch an
        // entry that was never written.
        for (int i = 0; i < PALETTE_ENTRIES; i++)
            send_request(OP_WRITE, INDEX_W'(i), COLOR_W'(i), COLOR_W'(i), COLOR_W'(i));

        foreach (directed_rows[k])
            send_request(directed_rows[k].op, directed_rows[k].entry,
                         directed_rows[k].red, directed_rows[k].green,
                         directed_rows[k].blue, directed_rows[k].typed,
                         directed_rows[k].best);

        // Idle both sides in turn, then run at full rate.
        run_phase(PAL_FEW);
        src_idle_pct  = 70;
        sink_idle_pct = 37;
        run_phase(PAL_FULL);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(PAL_EXTREME);

        // Drain, then give a stray response time to show up.
        wait_for_responses();
        repeat (SCAN_LATENCY + 8) @(posedge clk);
        if (fail_count == 0 && expected_best.size() == 0)
            $display("nearest_palette_color_search_unit_tb passed");
        else
            $display("nearest_palette_color_search_unit_tb failed");
        $finish;
    end

    initial
    begin
        #25000000;
        $display("nearest_palette_color_search_unit_tb failed");
        $finish;
    end

endmodule
